// ===== rtl/spbm_pkg.sv =====
// ----------------------------------------------------------------------------
// spbm_pkg
// widths, register map and constants of the stereo phase balance meter
// ----------------------------------------------------------------------------
`default_nettype none

package spbm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 17;
  localparam int MAG_W    = 17;
  localparam int SUM_W    = MAG_W + 1;
  localparam int PROD_W   = SAMPLE_W + GAIN_W;
  localparam int FRAC_W   = 15;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // register map, byte addresses
  localparam logic [APB_ADDR_W-1:0] REG_GAIN_Q15 = 3'd0;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd32768;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 17'd65536;

  // largest magnitude that is not a clip
  localparam logic [MAG_W-1:0] CLIP_LEVEL = 17'd32768;

  // one product lsb below one result lsb, for the ceiling of negative products
  localparam logic [PROD_W-1:0] ROUND_NEG = 33'd32767;

endpackage

`default_nettype wire

// ===== rtl/stereo_phase_balance_meter.sv =====
// ----------------------------------------------------------------------------
// stereo_phase_balance_meter
// per-window peak meter of stereo balance and phase over scaled sample pairs
// ----------------------------------------------------------------------------
// result path: a window's last item is registered in stage a, then stage b, then the output register
// throughput: one item per cycle while in_stall is low, set by the three-stage register pipeline
// in_stall rises only when a window-closing item is held by a full, stalled
//   output register; other items keep flowing into the peak registers
// reset: synchronous, clears valids and peaks, gain_q15 returns to unity
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_phase_balance_meter (
  input  wire logic                                   clk,
  input  wire logic                                   rst,

  // apb configuration port
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [spbm_pkg::APB_ADDR_W-1:0]        paddr,
  input  wire logic [spbm_pkg::APB_DATA_W-1:0]        pwdata,
  output logic      [spbm_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                        pready,

  // sample pairs in
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [spbm_pkg::SAMPLE_W-1:0]   left_sample,
  input  wire logic signed [spbm_pkg::SAMPLE_W-1:0]   right_sample,
  input  wire logic                                   window_last,

  // window results out
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [spbm_pkg::MAG_W-1:0]                  max_center,
  output logic [spbm_pkg::MAG_W-1:0]                  max_left,
  output logic [spbm_pkg::MAG_W-1:0]                  max_left_diff,
  output logic [spbm_pkg::MAG_W-1:0]                  max_right,
  output logic [spbm_pkg::MAG_W-1:0]                  max_right_diff,
  output logic [spbm_pkg::SUM_W-1:0]                  max_phase_center_sum,
  output logic [spbm_pkg::MAG_W-1:0]                  max_phase_center_diff,
  output logic [spbm_pkg::SUM_W-1:0]                  max_phase_left_sum,
  output logic [spbm_pkg::MAG_W-1:0]                  max_phase_left_diff,
  output logic [spbm_pkg::SUM_W-1:0]                  max_phase_right_sum,
  output logic [spbm_pkg::MAG_W-1:0]                  max_phase_right_diff,
  output logic                                        clipped
);

  import spbm_pkg::*;

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0] gain_q15;
  logic              cfg_write;
  logic              addr_gain;

  // word decode: the low byte-offset bits are ignored
  assign addr_gain = (paddr[APB_ADDR_W-1:2] == REG_GAIN_Q15[APB_ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && addr_gain;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_q15 <= GAIN_RESET;
    end else if (cfg_write) begin
      gain_q15 <= pwdata[GAIN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (addr_gain) begin
      prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, gain_q15};
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control
  // stage a holds the raw pair, stage b the scaled magnitudes, and the peak
  // registers plus the output register form the last stage
  // --------------------------------------------------------------------------
  logic a_valid;
  logic b_valid;
  logic b_last;
  logic out_free;
  logic b_go;
  logic adv;

  assign out_free = !out_valid || !out_stall;
  // a closing item needs the output register, any other item only the peaks
  assign b_go     = b_valid && (!b_last || out_free);
  assign adv      = !b_valid || b_go;
  assign in_stall = a_valid && !adv;

  // --------------------------------------------------------------------------
  // stage a: input register
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] a_left;
  logic signed [SAMPLE_W-1:0] a_right;
  logic                       a_last;
  logic                       in_take;

  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_take;
    end else if (in_take) begin
      a_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_left  <= left_sample;
      a_right <= right_sample;
      a_last  <= window_last;
    end
  end

  // --------------------------------------------------------------------------
  // scaling: magnitude times gain over 2^15, negative values round up in
  // magnitude so the signed result is a floor
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0]   gain_eff;
  logic                neg_l, neg_r;
  logic [SAMPLE_W-1:0] abs_l, abs_r;
  logic [PROD_W-1:0]   prod_l, prod_r;
  logic [PROD_W-1:0]   rnd_l, rnd_r;
  logic [MAG_W-1:0]    mag_l, mag_r;

  assign gain_eff = (gain_q15 > GAIN_MAX) ? GAIN_MAX : gain_q15;

  always_comb begin
    neg_l  = a_left[SAMPLE_W-1];
    neg_r  = a_right[SAMPLE_W-1];
    // the most negative sample gives 0x8000, still correct as unsigned
    abs_l  = neg_l ? (~a_left + 1'b1)  : a_left;
    abs_r  = neg_r ? (~a_right + 1'b1) : a_right;
    prod_l = {{GAIN_W{1'b0}}, abs_l} * {{SAMPLE_W{1'b0}}, gain_eff};
    prod_r = {{GAIN_W{1'b0}}, abs_r} * {{SAMPLE_W{1'b0}}, gain_eff};
    rnd_l  = neg_l ? (prod_l + ROUND_NEG) : prod_l;
    rnd_r  = neg_r ? (prod_r + ROUND_NEG) : prod_r;
    mag_l  = rnd_l[FRAC_W+MAG_W-1:FRAC_W];
    mag_r  = rnd_r[FRAC_W+MAG_W-1:FRAC_W];
  end

  // --------------------------------------------------------------------------
  // stage b: scaled magnitudes and signs
  // --------------------------------------------------------------------------
  logic [MAG_W-1:0] b_mag_l, b_mag_r;
  logic             b_neg_l, b_neg_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_mag_l <= mag_l;
      b_mag_r <= mag_r;
      b_neg_l <= neg_l;
      b_neg_r <= neg_r;
      b_last  <= a_last;
    end
  end

  // --------------------------------------------------------------------------
  // classification and peak update
  // --------------------------------------------------------------------------
  logic             opposite;
  logic             l_gt, r_gt;
  logic [SUM_W-1:0] pair_sum;
  logic [MAG_W-1:0] diff_lr, diff_rl;
  logic             clip_now;

  // a zero magnitude has no sign, so it never makes a phase pair
  assign opposite = (b_mag_l != '0) && (b_mag_r != '0) && (b_neg_l != b_neg_r);
  assign l_gt     = b_mag_l > b_mag_r;
  assign r_gt     = b_mag_r > b_mag_l;
  assign pair_sum = {1'b0, b_mag_l} + {1'b0, b_mag_r};
  assign diff_lr  = b_mag_l - b_mag_r;
  assign diff_rl  = b_mag_r - b_mag_l;
  assign clip_now = (b_mag_l > CLIP_LEVEL) || (b_mag_r > CLIP_LEVEL);

  logic [MAG_W-1:0] center_peak, left_peak, left_diff_peak;
  logic [MAG_W-1:0] right_peak, right_diff_peak;
  logic [SUM_W-1:0] phase_center_sum_peak, phase_left_sum_peak, phase_right_sum_peak;
  logic [MAG_W-1:0] phase_left_diff_peak, phase_right_diff_peak;
  logic             clip_seen;

  logic [MAG_W-1:0] center_peak_next, left_peak_next, left_diff_peak_next;
  logic [MAG_W-1:0] right_peak_next, right_diff_peak_next;
  logic [SUM_W-1:0] phase_center_sum_peak_next, phase_left_sum_peak_next;
  logic [SUM_W-1:0] phase_right_sum_peak_next;
  logic [MAG_W-1:0] phase_left_diff_peak_next, phase_right_diff_peak_next;
  logic             clip_seen_next;

  always_comb begin
    center_peak_next           = center_peak;
    left_peak_next             = left_peak;
    left_diff_peak_next        = left_diff_peak;
    right_peak_next            = right_peak;
    right_diff_peak_next       = right_diff_peak;
    phase_center_sum_peak_next = phase_center_sum_peak;
    phase_left_sum_peak_next   = phase_left_sum_peak;
    phase_left_diff_peak_next  = phase_left_diff_peak;
    phase_right_sum_peak_next  = phase_right_sum_peak;
    phase_right_diff_peak_next = phase_right_diff_peak;
    clip_seen_next             = clip_seen || clip_now;

    if (opposite) begin
      if (l_gt) begin
        if (pair_sum > phase_left_sum_peak)  phase_left_sum_peak_next  = pair_sum;
        if (diff_lr > phase_left_diff_peak)  phase_left_diff_peak_next = diff_lr;
      end else if (r_gt) begin
        if (pair_sum > phase_right_sum_peak) phase_right_sum_peak_next  = pair_sum;
        if (diff_rl > phase_right_diff_peak) phase_right_diff_peak_next = diff_rl;
      end else begin
        // equal magnitudes: the difference is zero and never raises its peak
        if (pair_sum > phase_center_sum_peak) phase_center_sum_peak_next = pair_sum;
      end
    end else if (l_gt) begin
      if (b_mag_l > left_peak)      left_peak_next      = b_mag_l;
      if (diff_lr > left_diff_peak) left_diff_peak_next = diff_lr;
    end else if (r_gt) begin
      if (b_mag_r > right_peak)      right_peak_next      = b_mag_r;
      if (diff_rl > right_diff_peak) right_diff_peak_next = diff_rl;
    end else begin
      if (b_mag_l > center_peak) center_peak_next = b_mag_l;
    end
  end

  // peaks take the item, or clear once the closing item is handed out
  always_ff @(posedge clk) begin
    if (rst || (b_go && b_last)) begin
      center_peak           <= '0;
      left_peak             <= '0;
      left_diff_peak        <= '0;
      right_peak            <= '0;
      right_diff_peak       <= '0;
      phase_center_sum_peak <= '0;
      phase_left_sum_peak   <= '0;
      phase_left_diff_peak  <= '0;
      phase_right_sum_peak  <= '0;
      phase_right_diff_peak <= '0;
      clip_seen             <= 1'b0;
    end else if (b_go) begin
      center_peak           <= center_peak_next;
      left_peak             <= left_peak_next;
      left_diff_peak        <= left_diff_peak_next;
      right_peak            <= right_peak_next;
      right_diff_peak       <= right_diff_peak_next;
      phase_center_sum_peak <= phase_center_sum_peak_next;
      phase_left_sum_peak   <= phase_left_sum_peak_next;
      phase_left_diff_peak  <= phase_left_diff_peak_next;
      phase_right_sum_peak  <= phase_right_sum_peak_next;
      phase_right_diff_peak <= phase_right_diff_peak_next;
      clip_seen             <= clip_seen_next;
    end
  end

  // --------------------------------------------------------------------------
  // output register: one result item per window
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_go && b_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_last) begin
      max_center            <= center_peak_next;
      max_left              <= left_peak_next;
      max_left_diff         <= left_diff_peak_next;
      max_right             <= right_peak_next;
      max_right_diff        <= right_diff_peak_next;
      max_phase_center_sum  <= phase_center_sum_peak_next;
      max_phase_center_diff <= '0;
      max_phase_left_sum    <= phase_left_sum_peak_next;
      max_phase_left_diff   <= phase_left_diff_peak_next;
      max_phase_right_sum   <= phase_right_sum_peak_next;
      max_phase_right_diff  <= phase_right_diff_peak_next;
      clipped               <= clip_seen_next;
    end
  end

endmodule

`default_nettype wire
